>>> src/thsv_pkg.sv
// Shared types, constants and the level mapping for the touch hold-and-slide volume block.
`default_nettype none
package thsv_pkg;

  localparam int LEVEL_STEPS = 20;
  localparam int VOL_MAX     = 100;

  // Level is (v * LEVEL_STEPS) / 100, done as a multiply by a reciprocal.
  // The product v * LEVEL_STEPS stays below 4096, where 1311 / 2^17 is exact enough.
  localparam int LVL_RECIP = 1311;
  localparam int LVL_SHIFT = 17;

  localparam int DIV_W  = 17;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  localparam logic [7:0]  BAR_LENGTH_RST   = 8'd100;
  localparam logic [15:0] HOLD_TICKS_RST   = 16'd400;
  localparam logic [10:0] STILL_LIMIT_RST  = 11'd10;
  localparam logic [9:0]  DRIFT_LIMIT_RST  = 10'd20;
  localparam logic [6:0]  START_VOLUME_RST = 7'd50;

  localparam logic [6:0] POLL_FAST = 7'd25;
  localparam logic [6:0] POLL_SLOW = 7'd100;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_HOLD  = 2'd1,
    MODE_SLIDE = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_CONTACT = 2'd1,
    EV_LIFT    = 2'd2,
    EV_NONE    = 2'd3
  } event_t;

  typedef enum logic [2:0] {
    CFG_BAR_LENGTH   = 3'd0,
    CFG_HOLD_TICKS   = 3'd1,
    CFG_STILL_LIMIT  = 3'd2,
    CFG_DRIFT_LIMIT  = 3'd3,
    CFG_START_VOLUME = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SEQ_READY,
    SEQ_EVAL,
    SEQ_DIV,
    SEQ_OUT
  } seq_t;

  function automatic logic [6:0] clamp_vol(input logic [6:0] v);
    logic [6:0] r;
    r = (v > 7'(VOL_MAX)) ? 7'(VOL_MAX) : v;
    return r;
  endfunction

  function automatic logic [4:0] level_of(input logic [6:0] v);
    logic [11:0] p;
    logic [22:0] prod;
    p    = 12'(v) * 12'(LEVEL_STEPS);
    prod = 23'(p) * 23'(LVL_RECIP);
    return prod[LVL_SHIFT +: 5];
  endfunction

endpackage
`default_nettype wire

>>> src/thsv_div.sv
// Restoring serial divider: one quotient bit per cycle, shared by every slide update.
`default_nettype none
module thsv_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [thsv_pkg::DIV_W-1:0] dividend,
  input  wire logic [7:0]                divisor,
  output logic                           done,
  output logic [thsv_pkg::DIV_W-1:0]     quotient
);
  import thsv_pkg::*;

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [7:0]        rem;
  logic [7:0]        dvs;
  logic [8:0]        trial;
  logic              fits;

  assign trial = {rem, quotient[DIV_W-1]};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DCNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      quotient <= dividend;
      dvs      <= divisor;
    end else if (busy) begin
      rem      <= fits ? 8'(trial - {1'b0, dvs}) : trial[7:0];
      quotient <= {quotient[DIV_W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

>>> src/touch_hold_slide_volume.sv
// Top level: hold-then-slide gesture sequencer with a shared serial divider.
//
//   channel | direction | handshake             | payload
//   input   | in        | in_valid / in_ready   | touch_present event_kind pos_x pos_y now_tick
//   result  | out       | out_valid / out_ready | mode volume volume_updated level
//           |           |                       | level_changed overlay_on poll_interval_ms
//   config  | in        | cfg_valid / cfg_ready | cfg_index cfg_data
//
// A poll that updates the volume passes through an evaluation state that also starts the
// divider, the divider's steps, one quotient bit each, the fold of the quotient into the
// pending volume when the divider is done, and the output state that loads the result.
// Every other poll goes from evaluation straight to the output state. The next poll can
// be taken in the cycle after the load, so the serial divider sets the longer spacing.
// Reset is synchronous; after it the block is ready at once, with no clearing pass.
// A new poll may be taken while the previous result still waits; the result register
// is only reloaded once it is free. Configuration writes are always taken.
`default_nettype none
module touch_hold_slide_volume (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        touch_present,
  input  wire logic [1:0]  event_kind,
  input  wire logic [9:0]  pos_x,
  input  wire logic [9:0]  pos_y,
  input  wire logic [31:0] now_tick,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       mode,
  output logic [6:0]       volume,
  output logic             volume_updated,
  output logic [4:0]       level,
  output logic             level_changed,
  output logic             overlay_on,
  output logic [6:0]       poll_interval_ms,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import thsv_pkg::*;

  seq_t seq, seq_next;

  // Configuration
  logic [7:0]  bar_length;
  logic [15:0] hold_ticks;
  logic [10:0] still_limit;
  logic [9:0]  drift_limit;

  // Captured poll
  logic        t_present;
  event_t      t_event;
  logic [9:0]  t_x;
  logic [9:0]  t_y;
  logic [31:0] t_now;

  // Gesture state
  mode_t       gesture_mode;
  logic [9:0]  anchor_x;
  logic [9:0]  anchor_y;
  logic [31:0] anchor_tick;
  logic [6:0]  base_volume;
  logic [6:0]  pending_volume;
  logic [4:0]  shown_level;
  logic        fast_poll;
  logic        overlay_shown;
  logic        upd_flag;
  logic        chg_flag;

  // Evaluation terms
  logic [9:0]       dx_mag;
  logic [9:0]       dy_mag;
  logic             dy_neg;
  logic [10:0]      manh;
  logic [31:0]      tick_diff;
  logic             hold_done;
  logic             arm, hold, slide, enter, divide, to_idle;
  logic [DIV_W-1:0] dividend;
  logic [7:0]       divisor;

  logic             div_start;
  logic             div_done;
  logic [DIV_W-1:0] quo;
  logic [17:0]      up_sum;
  logic [6:0]       new_vol;
  logic [4:0]       new_lvl;
  logic             out_load;

  assign cfg_ready = 1'b1;

  always_comb begin
    dx_mag    = (anchor_x >= t_x) ? 10'(anchor_x - t_x) : 10'(t_x - anchor_x);
    dy_neg    = anchor_y < t_y;
    dy_mag    = dy_neg ? 10'(t_y - anchor_y) : 10'(anchor_y - t_y);
    manh      = {1'b0, dx_mag} + {1'b0, dy_mag};
    tick_diff = t_now - anchor_tick;
    hold_done = tick_diff >= {16'd0, hold_ticks};
    arm       = t_present && (gesture_mode == MODE_IDLE)
                && ((t_event == EV_PRESS) || (t_event == EV_CONTACT));
    hold      = t_present && (gesture_mode == MODE_HOLD) && (t_event == EV_CONTACT);
    slide     = t_present && (gesture_mode == MODE_SLIDE) && (t_event == EV_CONTACT);
    enter     = hold && hold_done && (manh < still_limit);
    to_idle   = !(arm || hold || slide) || (hold && hold_done && !(manh < still_limit));
    divide    = slide && (dx_mag < drift_limit);
    dividend  = DIV_W'(dy_mag) * DIV_W'(VOL_MAX);
    divisor   = (bar_length == 8'd0) ? 8'd1 : bar_length;
  end

  // Signed quotient folded onto the base and clamped to the volume range.
  always_comb begin
    up_sum = 18'(base_volume) + 18'(quo);
    if (!dy_neg) begin
      new_vol = (up_sum > 18'(VOL_MAX)) ? 7'(VOL_MAX) : up_sum[6:0];
    end else begin
      new_vol = (quo >= DIV_W'(base_volume)) ? 7'd0 : 7'(base_volume - quo[6:0]);
    end
    new_lvl = level_of(new_vol);
  end

  thsv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= SEQ_READY;
    end else begin
      seq <= seq_next;
    end
  end

  always_comb begin
    seq_next = seq;
    unique case (seq)
      SEQ_READY: if (in_valid) seq_next = SEQ_EVAL;
      SEQ_EVAL:  seq_next = divide ? SEQ_DIV : SEQ_OUT;
      SEQ_DIV:   if (div_done) seq_next = SEQ_OUT;
      SEQ_OUT:   if (!out_valid || out_ready) seq_next = SEQ_READY;
      default:   seq_next = SEQ_READY;
    endcase
  end

  always_comb begin
    in_ready  = (seq == SEQ_READY);
    div_start = (seq == SEQ_EVAL) && divide;
    out_load  = (seq == SEQ_OUT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      t_present <= touch_present;
      t_event   <= event_t'(event_kind);
      t_x       <= pos_x;
      t_y       <= pos_y;
      t_now     <= now_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bar_length     <= BAR_LENGTH_RST;
      hold_ticks     <= HOLD_TICKS_RST;
      still_limit    <= STILL_LIMIT_RST;
      drift_limit    <= DRIFT_LIMIT_RST;
      gesture_mode   <= MODE_IDLE;
      anchor_x       <= '0;
      anchor_y       <= '0;
      anchor_tick    <= '0;
      base_volume    <= clamp_vol(START_VOLUME_RST);
      pending_volume <= '0;
      shown_level    <= level_of(clamp_vol(START_VOLUME_RST));
      fast_poll      <= 1'b0;
      overlay_shown  <= 1'b0;
      upd_flag       <= 1'b0;
      chg_flag       <= 1'b0;
    end else begin
      if (seq == SEQ_EVAL) begin
        upd_flag <= 1'b0;
        chg_flag <= 1'b0;
        if (to_idle) begin
          // Leaving the slide commits what was set.
          if (gesture_mode == MODE_SLIDE) base_volume <= pending_volume;
          gesture_mode  <= MODE_IDLE;
          anchor_tick   <= '0;
          fast_poll     <= 1'b0;
          overlay_shown <= 1'b0;
        end else if (arm) begin
          anchor_x     <= t_x;
          anchor_y     <= t_y;
          anchor_tick  <= t_now;
          fast_poll    <= 1'b1;
          gesture_mode <= MODE_HOLD;
        end else if (enter) begin
          gesture_mode   <= MODE_SLIDE;
          overlay_shown  <= 1'b1;
          fast_poll      <= 1'b1;
          pending_volume <= base_volume;
        end
      end
      if ((seq == SEQ_DIV) && div_done) begin
        pending_volume <= new_vol;
        upd_flag       <= 1'b1;
        if (new_lvl != shown_level) begin
          shown_level <= new_lvl;
          chg_flag    <= 1'b1;
        end
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_BAR_LENGTH:  bar_length  <= cfg_data[7:0];
          CFG_HOLD_TICKS:  hold_ticks  <= cfg_data;
          CFG_STILL_LIMIT: still_limit <= cfg_data[10:0];
          CFG_DRIFT_LIMIT: drift_limit <= cfg_data[9:0];
          CFG_START_VOLUME: begin
            base_volume <= clamp_vol(cfg_data[6:0]);
            shown_level <= level_of(clamp_vol(cfg_data[6:0]));
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      mode             <= gesture_mode;
      volume           <= (gesture_mode == MODE_SLIDE) ? pending_volume : base_volume;
      volume_updated   <= upd_flag;
      level            <= shown_level;
      level_changed    <= chg_flag;
      overlay_on       <= overlay_shown;
      poll_interval_ms <= fast_poll ? POLL_FAST : POLL_SLOW;
    end
  end

endmodule
`default_nettype wire

>>> src/thsv_chk.sv
// Port-level checker for the touch hold-and-slide volume block, with its bind.
`default_nettype none
module thsv_chk (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] mode,
  input wire logic [6:0] volume,
  input wire logic       volume_updated,
  input wire logic       level_changed,
  input wire logic       overlay_on,
  input wire logic [6:0] poll_interval_ms
);
  import thsv_pkg::*;

  // A held result must not move until its transfer.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(volume) && $stable(mode))
    else $error("result changed while stalled");

  // The block works on one poll at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second poll taken while busy");

  a_idle_view: assert property (@(posedge clk) disable iff (rst)
    out_valid && (mode == MODE_IDLE) |-> !overlay_on && (poll_interval_ms == POLL_SLOW))
    else $error("idle result shows overlay or fast poll");

  a_slide_view: assert property (@(posedge clk) disable iff (rst)
    out_valid && (mode == MODE_SLIDE) |-> overlay_on && (poll_interval_ms == POLL_FAST))
    else $error("sliding result without overlay or fast poll");

  // A redraw or a new volume only comes from a slide update.
  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && (volume_updated || level_changed) |->
      (mode == MODE_SLIDE) && volume_updated)
    else $error("update flags outside a slide update");

endmodule

bind touch_hold_slide_volume thsv_chk u_thsv_chk (.*);
`default_nettype wire

>>> sim/thsv_volume_checker.sv
// Checker for the touch hold-and-slide volume block: predicts each poll's report and compares it.
module thsv_volume_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        touch_present,
  input  logic [1:0]  event_kind,
  input  logic [9:0]  pos_x,
  input  logic [9:0]  pos_y,
  input  logic [31:0] now_tick,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  mode,
  input  logic [6:0]  volume,
  input  logic        volume_updated,
  input  logic [4:0]  level,
  input  logic        level_changed,
  input  logic        overlay_on,
  input  logic [6:0]  poll_interval_ms,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          awaited
);
  import thsv_pkg::*;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] volume;
    logic       updated;
    logic [4:0] level;
    logic       changed;
    logic       overlay;
    logic [6:0] poll_ms;
  } volume_report_t;

  volume_report_t due_reports[$];

  // Register copies.
  logic [7:0]  bar_length;
  logic [15:0] hold_ticks;
  logic [10:0] still_limit;
  logic [9:0]  drift_limit;
  logic [6:0]  start_volume;

  // Gesture state.
  mode_t       gesture;
  logic [9:0]  anchor_x;
  logic [9:0]  anchor_y;
  logic [31:0] anchor_tick;
  logic [6:0]  base_vol;
  logic [6:0]  pend_vol;
  logic [4:0]  shown_level;
  logic        fast_poll;
  logic        overlay;

  function automatic logic [6:0] saturate_volume(input logic [6:0] v);
    return (v > 7'(VOL_MAX)) ? 7'(VOL_MAX) : v;
  endfunction

  function automatic logic [4:0] steps_for(input logic [6:0] v);
    int scaled;
    scaled = int'(v) * LEVEL_STEPS;
    return 5'(scaled / VOL_MAX);
  endfunction

  // Leaving a gesture commits the slide volume only when it came from sliding.
  function automatic void drop_gesture();
    if (gesture == MODE_SLIDE) begin
      base_vol = pend_vol;
    end
    gesture     = MODE_IDLE;
    anchor_tick = '0;
    fast_poll   = 1'b0;
    overlay     = 1'b0;
  endfunction

  function automatic void apply_register(input logic [2:0] idx, input logic [15:0] data);
    case (idx)
      CFG_BAR_LENGTH:   bar_length  = data[7:0];
      CFG_HOLD_TICKS:   hold_ticks  = data;
      CFG_STILL_LIMIT:  still_limit = data[10:0];
      CFG_DRIFT_LIMIT:  drift_limit = data[9:0];
      CFG_START_VOLUME: begin
        start_volume = data[6:0];
        base_vol     = saturate_volume(start_volume);
        shown_level  = steps_for(base_vol);
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_poll(input logic present, input logic [1:0] ev,
                                       input logic [9:0] x, input logic [9:0] y,
                                       input logic [31:0] tick,
                                       output volume_report_t rep);
    int          dx, dy, adx, ady, span, vol;
    logic [31:0] held;
    logic [4:0]  lv;
    rep.updated = 1'b0;
    rep.changed = 1'b0;
    dx  = int'(anchor_x) - int'(x);
    dy  = int'(anchor_y) - int'(y);
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    if (!present) begin
      drop_gesture();
    end else if (gesture == MODE_IDLE && (ev == EV_PRESS || ev == EV_CONTACT)) begin
      anchor_x    = x;
      anchor_y    = y;
      anchor_tick = tick;
      fast_poll   = 1'b1;
      gesture     = MODE_HOLD;
    end else if (gesture == MODE_HOLD && ev == EV_CONTACT) begin
      held = tick - anchor_tick;
      if (held >= 32'(hold_ticks)) begin
        if (adx + ady < int'(still_limit)) begin
          gesture   = MODE_SLIDE;
          overlay   = 1'b1;
          fast_poll = 1'b1;
          pend_vol  = base_vol;
        end else begin
          drop_gesture();
        end
      end
    end else if (gesture == MODE_SLIDE && ev == EV_CONTACT) begin
      if (adx < int'(drift_limit)) begin
        span = (bar_length == 8'd0) ? 1 : int'(bar_length);
        // Integer division truncates toward zero before the base is added.
        vol = (dy * 100) / span + int'(base_vol);
        if (vol > VOL_MAX) vol = VOL_MAX;
        if (vol < 0) vol = 0;
        pend_vol    = 7'(vol);
        rep.updated = 1'b1;
        lv = steps_for(pend_vol);
        if (lv != shown_level) begin
          shown_level = lv;
          rep.changed = 1'b1;
        end
      end
    end else begin
      drop_gesture();
    end
    rep.mode    = gesture;
    rep.volume  = (gesture == MODE_SLIDE) ? pend_vol : base_vol;
    rep.level   = shown_level;
    rep.overlay = overlay;
    rep.poll_ms = fast_poll ? POLL_FAST : POLL_SLOW;
  endfunction

  function automatic void check_field(input string fname, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, fname, want, got);
      fail_count = fail_count + 1;
    end
  endfunction

  always @(posedge clk) begin : watch
    volume_report_t want;
    volume_report_t got;
    if (rst) begin
      bar_length   = BAR_LENGTH_RST;
      hold_ticks   = HOLD_TICKS_RST;
      still_limit  = STILL_LIMIT_RST;
      drift_limit  = DRIFT_LIMIT_RST;
      start_volume = START_VOLUME_RST;
      gesture      = MODE_IDLE;
      anchor_x     = '0;
      anchor_y     = '0;
      anchor_tick  = '0;
      base_vol     = saturate_volume(start_volume);
      pend_vol     = '0;
      shown_level  = steps_for(base_vol);
      fast_poll    = 1'b0;
      overlay      = 1'b0;
      due_reports.delete();
      fail_count   = 0;
      awaited      = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        apply_register(cfg_index, cfg_data);
      end
      if (out_valid && out_ready) begin
        got.mode    = mode;
        got.volume  = volume;
        got.updated = volume_updated;
        got.level   = level;
        got.changed = level_changed;
        got.overlay = overlay_on;
        got.poll_ms = poll_interval_ms;
        if (due_reports.size() == 0) begin
          $display("%0t: result transfer expected none, got mode %0d volume %0d",
                   $time, mode, volume);
          fail_count = fail_count + 1;
        end else begin
          want = due_reports.pop_front();
          check_field("mode", want.mode, got.mode);
          check_field("volume", want.volume, got.volume);
          check_field("volume_updated", want.updated, got.updated);
          check_field("level", want.level, got.level);
          check_field("level_changed", want.changed, got.changed);
          check_field("overlay_on", want.overlay, got.overlay);
          check_field("poll_interval_ms", want.poll_ms, got.poll_ms);
        end
      end
      // A result cannot leave in the cycle its poll is taken, so predicting last is safe.
      if (in_valid && in_ready) begin
        predict_poll(touch_present, event_kind, pos_x, pos_y, now_tick, want);
        due_reports.push_back(want);
      end
      awaited = due_reports.size();
    end
  end

endmodule

>>> sim/tb_touch_hold_slide_volume.sv
// Testbench top for the touch hold-and-slide volume block: stimulus, idling and the verdict.
module tb_touch_hold_slide_volume;
  import thsv_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        touch_present = 1'b0;
  logic [1:0]  event_kind = EV_NONE;
  logic [9:0]  pos_x = '0;
  logic [9:0]  pos_y = '0;
  logic [31:0] now_tick = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  mode;
  logic [6:0]  volume;
  logic        volume_updated;
  logic [4:0]  level;
  logic        level_changed;
  logic        overlay_on;
  logic [6:0]  poll_interval_ms;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = CFG_BAR_LENGTH;
  logic [15:0] cfg_data = '0;
  int          fail_count;
  int          awaited;

  // Percentage chance of an idle burst, shared by both sides; zero means none.
  int gap_odds = 0;
  int polls_sent = 0;

  // What has been written, so that gestures can be shaped to get past the hold check.
  int bar_cfg   = 100;
  int hold_cfg  = 400;
  int still_cfg = 10;
  int drift_cfg = 20;

  touch_hold_slide_volume dut (.*);

  thsv_volume_checker checker_i (.*);

  always #5 clk = ~clk;

  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side back-pressure.
  initial begin
    forever begin
      @(negedge clk);
      if (gap_odds > 0 && $urandom_range(0, 99) < gap_odds) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic send_poll(input logic present, input event_t ev, input logic [9:0] x,
                           input logic [9:0] y, input logic [31:0] tick);
    if (gap_odds > 0 && $urandom_range(0, 99) < gap_odds) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 15)) @(negedge clk);
    end
    @(negedge clk);
    in_valid      = 1'b1;
    touch_present = present;
    event_kind    = ev;
    pos_x         = x;
    pos_y         = y;
    now_tick      = tick;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    polls_sent++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Unused upper data bits carry noise; the block must ignore them.
  task automatic set_config(input int bar, input int hold, input int still, input int drift,
                            input int start);
    write_reg(CFG_BAR_LENGTH, {8'($urandom), 8'(bar)});
    write_reg(CFG_HOLD_TICKS, 16'(hold));
    write_reg(CFG_STILL_LIMIT, {5'($urandom), 11'(still)});
    write_reg(CFG_DRIFT_LIMIT, {6'($urandom), 10'(drift)});
    write_reg(CFG_START_VOLUME, {9'($urandom), 7'(start)});
    bar_cfg   = bar;
    hold_cfg  = hold;
    still_cfg = still;
    drift_cfg = drift;
  endtask

  // Lets every outstanding result drain, then allows for the slowest poll's latency.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  function automatic logic [9:0] nudge(input logic [9:0] from, input int by);
    int v;
    v = $urandom_range(0, 1) ? int'(from) + by : int'(from) - by;
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return 10'(v);
  endfunction

  // A touch-down, a hold check and slide attempts, ended in one of several ways or left open.
  task automatic run_gesture();
    logic [9:0]  x0, y0;
    logic [31:0] t;
    int          m, sx, span, dxo, dyo;
    x0 = 10'($urandom);
    y0 = 10'($urandom);
    t  = $urandom;
    send_poll(1'b1, ($urandom_range(0, 3) == 0) ? EV_CONTACT : EV_PRESS, x0, y0, t);
    if (hold_cfg > 0) begin
      repeat ($urandom_range(0, 2))
        send_poll(1'b1, EV_CONTACT, nudge(x0, $urandom_range(0, 3)),
                  nudge(y0, $urandom_range(0, 3)), t + $urandom_range(0, hold_cfg - 1));
    end
    if ($urandom_range(0, 99) < 80) begin
      m = (still_cfg == 0) ? 0 : $urandom_range(0, (still_cfg > 40) ? 40 : still_cfg - 1);
    end else begin
      m = still_cfg + $urandom_range(0, 20);
    end
    sx = $urandom_range(0, m);
    send_poll(1'b1, EV_CONTACT, nudge(x0, sx), nudge(y0, m - sx),
              t + 32'(hold_cfg) + $urandom_range(0, 40));
    span = (bar_cfg == 0) ? 1 : bar_cfg;
    repeat ($urandom_range(1, 10)) begin
      if ($urandom_range(0, 99) < 85) begin
        dxo = (drift_cfg == 0) ? 0 : $urandom_range(0, drift_cfg - 1);
      end else begin
        dxo = drift_cfg + $urandom_range(0, 10);
      end
      dyo = $urandom_range(0, span * 3 / 2 + 10);
      send_poll(1'b1, EV_CONTACT, nudge(x0, dxo), nudge(y0, dyo), $urandom);
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3: send_poll(1'b1, EV_LIFT, 10'($urandom), 10'($urandom), $urandom);
      4, 5: send_poll(1'b0, event_t'($urandom_range(0, 3)), 10'($urandom), 10'($urandom),
                      $urandom);
      6: send_poll(1'b1, EV_NONE, 10'($urandom), 10'($urandom), $urandom);
      7: send_poll(1'b1, EV_PRESS, 10'($urandom), 10'($urandom), $urandom);
      default: ;
    endcase
  endtask

  task automatic random_polls(input int count, input bit allow_idle);
    int first;
    first = polls_sent;
    while (polls_sent - first < count) begin
      if (allow_idle && $urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: gap_odds = 0;
          1: gap_odds = 5;
          2: gap_odds = 20;
          default: gap_odds = 50;
        endcase
      end
      if ($urandom_range(0, 99) < 15) begin
        send_poll(1'(2'($urandom)), event_t'($urandom_range(0, 3)), 10'($urandom),
                  10'($urandom), $urandom);
      end else begin
        run_gesture();
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed polls with the reset configuration.
    gap_odds = 10;
    send_poll(1'b1, EV_PRESS, 10'd500, 10'd500, 32'd1000);
    send_poll(1'b1, EV_CONTACT, 10'd500, 10'd500, 32'd1200);   // hold not yet over
    send_poll(1'b1, EV_CONTACT, 10'd505, 10'd504, 32'd1400);   // enters sliding
    send_poll(1'b1, EV_CONTACT, 10'd500, 10'd450, 32'd1425);   // reaches the top
    send_poll(1'b1, EV_CONTACT, 10'd500, 10'd1023, 32'd1450);  // clamps at zero
    send_poll(1'b1, EV_CONTACT, 10'd520, 10'd480, 32'd1475);   // drift at the limit
    send_poll(1'b1, EV_CONTACT, 10'd481, 10'd475, 32'd1500);
    send_poll(1'b1, EV_LIFT, 10'd481, 10'd475, 32'd1525);      // commits the slide
    send_poll(1'b0, EV_NONE, 10'd0, 10'd0, 32'd1550);
    send_poll(1'b1, EV_CONTACT, 10'd0, 10'd0, 32'hFFFF_FF00);
    send_poll(1'b1, EV_CONTACT, 10'd9, 10'd0, 32'h0000_0100);  // tick wraps
    send_poll(1'b1, EV_CONTACT, 10'd0, 10'd0, 32'h0000_0200);
    send_poll(1'b1, EV_PRESS, 10'd0, 10'd0, 32'h0000_0300);
    send_poll(1'b1, EV_PRESS, 10'd1023, 10'd1023, 32'd0);
    send_poll(1'b1, EV_CONTACT, 10'd1013, 10'd1023, 32'd500);  // moved during the hold
    send_poll(1'b1, EV_PRESS, 10'd1023, 10'd1023, 32'd0);
    send_poll(1'b1, EV_LIFT, 10'd1023, 10'd1023, 32'd10);
    send_poll(1'b1, EV_NONE, 10'd341, 10'd682, 32'hAAAA_AAAA);
    send_poll(1'b1, EV_PRESS, 10'd682, 10'd341, 32'h5555_5555);
    send_poll(1'b0, EV_CONTACT, 10'd682, 10'd341, 32'h5555_5600);
    send_poll(1'b1, EV_PRESS, 10'd100, 10'd600, 32'hFFFF_FFFF);
    send_poll(1'b1, EV_CONTACT, 10'd100, 10'd600, 32'h0000_018F);
    send_poll(1'b1, EV_CONTACT, 10'd100, 10'd0, 32'h0000_01A0);
    send_poll(1'b1, EV_NONE, 10'd100, 10'd0, 32'h0000_01B0);
    random_polls(150, 1'b1);
    settle();

    set_config(1, 0, 2047, 1023, 0);
    random_polls(90, 1'b1);
    settle();

    set_config(255, 65535, 1, 1, 100);
    random_polls(70, 1'b1);
    settle();

    // A zero bar length and a start volume beyond the top of the range.
    set_config(0, 5, 0, 0, 127);
    random_polls(40, 1'b1);
    settle();

    repeat (2) begin
      set_config($urandom_range(0, 255),
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 1000),
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 80),
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 80),
                 $urandom_range(0, 127));
      random_polls(100, 1'b1);
      settle();
    end

    gap_odds = 0;
    random_polls(60, 1'b0);
    settle();

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
